/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLY(label, clk, rst_n, cond, prop)
`define ASSERT_NEXT(label, clk, rst_n, cond, prop)
`endif
`endif

/* hw/rtl/ucrr_pkg.sv */
// Types, request keys and descriptor tables of the control request responder.
package ucrr_pkg;

    typedef enum logic [1:0] {
        KIND_DATA  = 2'd0,
        KIND_ACK   = 2'd1,
        KIND_STALL = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        SRC_DEV,
        SRC_CFG,
        SRC_LANG,
        SRC_MAKER,
        SRC_PROD,
        SRC_SER,
        SRC_BYTE0,
        SRC_LINE
    } t_src;

    localparam logic [15:0] KEY_GET_DESC    = 16'h0680;
    localparam logic [15:0] KEY_SET_ADDR    = 16'h0500;
    localparam logic [15:0] KEY_SET_CONF    = 16'h0900;
    localparam logic [15:0] KEY_GET_CONF    = 16'h0880;
    localparam logic [15:0] KEY_STAT_DEV    = 16'h0080;
    localparam logic [15:0] KEY_STAT_IF     = 16'h0081;
    localparam logic [15:0] KEY_STAT_EP     = 16'h0082;
    localparam logic [15:0] KEY_SETF_DEV    = 16'h0300;
    localparam logic [15:0] KEY_CLRF_DEV    = 16'h0100;
    localparam logic [15:0] KEY_SETF_IF     = 16'h0301;
    localparam logic [15:0] KEY_CLRF_IF     = 16'h0101;
    localparam logic [15:0] KEY_SETF_EP     = 16'h0302;
    localparam logic [15:0] KEY_CLRF_EP     = 16'h0102;
    localparam logic [15:0] KEY_SET_LINE    = 16'h2021;
    localparam logic [15:0] KEY_GET_LINE    = 16'h21A1;
    localparam logic [15:0] KEY_SET_CTL     = 16'h2221;
    localparam logic [7:0]  REQ_CLR_FEATURE = 8'h01;

    localparam logic [15:0] DESC_DEVICE  = 16'h0100;
    localparam logic [15:0] DESC_CONFIG  = 16'h0200;
    localparam logic [15:0] DESC_LANG    = 16'h0300;
    localparam logic [15:0] DESC_MAKER   = 16'h0301;
    localparam logic [15:0] DESC_PRODUCT = 16'h0302;
    localparam logic [15:0] DESC_SERIAL  = 16'h0303;

    localparam logic [6:0] LEN_DEVICE = 7'd18;
    localparam logic [6:0] LEN_CONFIG = 7'd67;
    localparam logic [6:0] LEN_LANG   = 7'd4;
    localparam logic [6:0] LEN_MAKER  = 7'd18;
    localparam logic [6:0] LEN_PROD   = 7'd2;
    localparam logic [6:0] LEN_SER    = 7'd4;
    localparam logic [6:0] LEN_LINE   = 7'd7;

    localparam logic [31:0] LINE_RATE_RESET = 32'd115200;
    localparam logic [7:0]  LINE_BITS_RESET = 8'd8;
    localparam int          MAX_ITEMS       = 9;

    // Tables hold the first byte in the lowest bits.
    localparam logic [143:0] ROM_DEVICE =
        144'h01_03_02_01_01_10_61_27_03_EB_40_00_00_02_02_00_01_12;
    localparam logic [535:0] ROM_CONFIG = {
        56'h00_00_40_02_82_05_07,
        56'h00_00_40_02_01_05_07,
        72'h00_00_00_0A_02_00_01_04_09,
        56'hFF_00_08_03_83_05_07,
        40'h01_00_01_24_05,
        40'h01_00_06_24_05,
        32'h00_02_24_04,
        40'h01_10_00_24_05,
        72'h00_00_02_02_01_00_00_04_09,
        72'h00_C0_00_01_02_00_43_02_09
    };
    localparam logic [31:0]  ROM_LANG    = 32'h04_09_03_04;
    localparam logic [143:0] ROM_MAKER   =
        144'h00_6B_00_6E_00_69_00_6C_00_6F_00_74_00_70_00_6F_03_12;
    localparam logic [15:0]  ROM_PRODUCT = 16'h03_02;
    localparam logic [31:0]  ROM_SERIAL  = 32'h00_30_03_04;

endpackage

/* hw/rtl/ucrr_ram.sv */
// Generic single-port-write, registered-read RAM.
module ucrr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* hw/rtl/usb_control_request_responder_unit.sv */
// Top level of the control-endpoint request responder.
// Usage:
// The slave stream carries one transaction per setup packet or bus reset
// (tuser high marks a bus reset). The master stream returns the reply as
// one or more transactions: a data chunk of up to BYTES_PER_RESULT bytes,
// a zero-length ack, a stall or a no-reply marker; tlast closes the reply.
// The request is registered into the reply generator, which then registers
// the first reply transaction in the output register. The next request is
// accepted in the same cycle as the last transaction of the current reply
// is produced. The reply generator, one chunk per cycle while the receiver
// keeps tready high, sets the rate at which requests are taken.
// Line coding lives in a small registered-read RAM.
// Reset clears all bus state and restores the default line coding; a bus
// reset transaction clears bus state but keeps the line coding.
// When the receiver stalls, the output register holds its transaction and
// the generator waits; no transaction is lost.
module usb_control_request_responder_unit #(
    parameter int MAX_PACKET       = 64,
    parameter int BYTES_PER_RESULT = 8
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // request_type, request_code, setup_value, setup_index, setup_length,
    // coding_rate, coding_stop_bits, coding_parity, coding_data_bits
    input  logic [119:0] i_s_tdata,
    // command
    input  logic         i_s_tuser,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // reply_kind, payload, byte_count, packet_end, zero pad
    output logic [71:0]  o_m_tdata,
    output logic         o_m_tlast
);
    localparam int PW = $clog2(MAX_PACKET + 1);

    logic [7:0]  w_rtype, w_rcode;
    logic [15:0] w_value, w_index, w_length, w_key;
    logic [3:0]  w_ep;
    logic        w_acc;

    assign w_rtype  = i_s_tdata[7:0];
    assign w_rcode  = i_s_tdata[15:8];
    assign w_value  = i_s_tdata[31:16];
    assign w_index  = i_s_tdata[47:32];
    assign w_length = i_s_tdata[63:48];
    assign w_key    = {w_rcode, w_rtype};
    assign w_ep     = w_index[3:0];
    assign w_acc    = i_s_tvalid && o_s_tready;

    // Bus state.
    logic [6:0] r_addr, n_addr;
    logic       r_addr_en, n_addr_en, r_cfg_flag, n_cfg_flag;
    logic [7:0] r_cfg_num, n_cfg_num;
    logic [3:0] r_ep_en, n_ep_en;
    logic       r_line_ok;

    // Reply generator.
    logic       r_busy;
    ucrr_pkg::t_kind r_kind, n_kind;
    ucrr_pkg::t_src  r_src, n_src;
    logic [6:0] r_len, n_len, r_pos;
    logic [7:0] r_b0, n_b0;
    logic [PW-1:0] r_inpkt;
    logic [3:0] r_cnt;

    logic        w_line_we;
    logic [55:0] w_line_rd, w_line;

    ucrr_ram #(.WIDTH(56), .DEPTH(2)) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (w_line_we),
        .i_waddr (1'b0),
        .i_wdata (i_s_tdata[119:64]),
        .i_raddr (1'b0),
        .o_rdata (w_line_rd)
    );

    localparam logic [7:0] LINE_BITS_RESET_W = ucrr_pkg::LINE_BITS_RESET;
    assign w_line = r_line_ok ? w_line_rd
                  : {LINE_BITS_RESET_W, 16'd0, ucrr_pkg::LINE_RATE_RESET};

    // Request decode.
    always_comb begin
        n_addr    = r_addr;
        n_addr_en = r_addr_en;
        n_cfg_flag = r_cfg_flag;
        n_cfg_num = r_cfg_num;
        n_ep_en   = r_ep_en;
        n_kind    = ucrr_pkg::KIND_STALL;
        n_src     = ucrr_pkg::SRC_BYTE0;
        n_len     = 7'd0;
        n_b0      = 8'd0;
        w_line_we = 1'b0;
        if (i_s_tuser) begin
            n_kind     = ucrr_pkg::KIND_NONE;
            n_addr     = 7'd0;
            n_addr_en  = 1'b0;
            n_cfg_flag = 1'b0;
            n_cfg_num  = 8'd0;
            n_ep_en    = 4'b0001;
        end else begin
            case (w_key)
                ucrr_pkg::KEY_GET_DESC: begin
                    n_kind = ucrr_pkg::KIND_DATA;
                    case (w_value)
                        ucrr_pkg::DESC_DEVICE: begin
                            n_src = ucrr_pkg::SRC_DEV;
                            n_len = ucrr_pkg::LEN_DEVICE;
                        end
                        ucrr_pkg::DESC_CONFIG: begin
                            n_src = ucrr_pkg::SRC_CFG;
                            n_len = (w_length < 16'(ucrr_pkg::LEN_CONFIG))
                                  ? w_length[6:0] : ucrr_pkg::LEN_CONFIG;
                        end
                        ucrr_pkg::DESC_LANG: begin
                            n_src = ucrr_pkg::SRC_LANG;
                            n_len = ucrr_pkg::LEN_LANG;
                        end
                        ucrr_pkg::DESC_MAKER: begin
                            n_src = ucrr_pkg::SRC_MAKER;
                            n_len = ucrr_pkg::LEN_MAKER;
                        end
                        ucrr_pkg::DESC_PRODUCT: begin
                            n_src = ucrr_pkg::SRC_PROD;
                            n_len = ucrr_pkg::LEN_PROD;
                        end
                        ucrr_pkg::DESC_SERIAL: begin
                            n_src = ucrr_pkg::SRC_SER;
                            n_len = ucrr_pkg::LEN_SER;
                        end
                        default: n_kind = ucrr_pkg::KIND_STALL;
                    endcase
                end
                ucrr_pkg::KEY_SET_ADDR: begin
                    n_addr    = w_value[6:0];
                    n_addr_en = 1'b1;
                    n_kind    = ucrr_pkg::KIND_ACK;
                end
                ucrr_pkg::KEY_SET_CONF: begin
                    n_cfg_num    = w_value[7:0];
                    n_cfg_flag   = (w_value != 16'd0);
                    n_ep_en[3:1] = {3{w_value != 16'd0}};
                    n_kind       = ucrr_pkg::KIND_ACK;
                end
                ucrr_pkg::KEY_GET_CONF: begin
                    n_kind = ucrr_pkg::KIND_DATA;
                    n_len  = 7'd1;
                    n_b0   = r_cfg_num;
                end
                ucrr_pkg::KEY_STAT_DEV, ucrr_pkg::KEY_STAT_IF: begin
                    n_kind = ucrr_pkg::KIND_DATA;
                    n_len  = 7'd2;
                end
                ucrr_pkg::KEY_STAT_EP: begin
                    if ((r_cfg_flag && w_ep <= 4'd3) || (r_addr_en && w_ep == 4'd0)) begin
                        n_kind = ucrr_pkg::KIND_DATA;
                        n_len  = 7'd2;
                        n_b0   = {7'd0, !r_ep_en[w_ep[1:0]]};
                    end
                end
                ucrr_pkg::KEY_SETF_DEV, ucrr_pkg::KEY_CLRF_DEV: begin
                    n_kind = ucrr_pkg::KIND_STALL;
                end
                ucrr_pkg::KEY_SETF_IF, ucrr_pkg::KEY_CLRF_IF: begin
                    n_kind = ucrr_pkg::KIND_ACK;
                end
                ucrr_pkg::KEY_SETF_EP, ucrr_pkg::KEY_CLRF_EP: begin
                    if (w_value == 16'd0 && w_ep >= 4'd1 && w_ep <= 4'd3) begin
                        n_ep_en[w_ep[1:0]] = (w_rcode == ucrr_pkg::REQ_CLR_FEATURE);
                        n_kind = ucrr_pkg::KIND_ACK;
                    end
                end
                ucrr_pkg::KEY_SET_LINE: begin
                    w_line_we = w_acc;
                    n_kind    = ucrr_pkg::KIND_ACK;
                end
                ucrr_pkg::KEY_GET_LINE: begin
                    n_kind = ucrr_pkg::KIND_DATA;
                    n_src  = ucrr_pkg::SRC_LINE;
                    n_len  = ucrr_pkg::LEN_LINE;
                end
                ucrr_pkg::KEY_SET_CTL: n_kind = ucrr_pkg::KIND_ACK;
                default: n_kind = ucrr_pkg::KIND_STALL;
            endcase
            // An empty data reply turns into a zero-length ack.
            if (n_kind == ucrr_pkg::KIND_DATA && n_len == 7'd0) begin
                n_kind = ucrr_pkg::KIND_ACK;
            end
        end
    end

    function automatic logic [7:0] f_byte(ucrr_pkg::t_src s, logic [6:0] idx,
                                          logic [7:0] b0, logic [55:0] line);
        logic [9:0] sh;
        logic [7:0] res;
        sh = {idx, 3'b000};
        case (s)
            ucrr_pkg::SRC_DEV:   res = 8'(ucrr_pkg::ROM_DEVICE >> sh);
            ucrr_pkg::SRC_CFG:   res = 8'(ucrr_pkg::ROM_CONFIG >> sh);
            ucrr_pkg::SRC_LANG:  res = 8'(ucrr_pkg::ROM_LANG >> sh);
            ucrr_pkg::SRC_MAKER: res = 8'(ucrr_pkg::ROM_MAKER >> sh);
            ucrr_pkg::SRC_PROD:  res = 8'(ucrr_pkg::ROM_PRODUCT >> sh);
            ucrr_pkg::SRC_SER:   res = 8'(ucrr_pkg::ROM_SERIAL >> sh);
            ucrr_pkg::SRC_LINE:  res = 8'(line >> sh);
            ucrr_pkg::SRC_BYTE0: res = (idx == 7'd0) ? b0 : 8'd0;
            default:             res = 8'd0;
        endcase
        return res;
    endfunction

    // Chunk generation.
    logic [6:0]    w_rem, w_room, w_n, w_npos;
    logic [PW:0]   w_nin;
    logic [63:0]   w_pay;
    logic          w_pend, w_last, w_push;
    logic [3:0]    w_cnt_out;

    always_comb begin
        w_rem  = r_len - r_pos;
        w_room = 7'(MAX_PACKET - int'(r_inpkt));
        w_n    = 7'(BYTES_PER_RESULT);
        if (w_rem < w_n) w_n = w_rem;
        if (w_room < w_n) w_n = w_room;
        w_pay = 64'd0;
        for (int i = 0; i < BYTES_PER_RESULT; i++) begin
            if (7'(i) < w_n) begin
                w_pay[i*8 +: 8] = f_byte(r_src, r_pos + 7'(i), r_b0, w_line);
            end
        end
        w_npos = r_pos + w_n;
        w_nin  = {1'b0, r_inpkt} + (PW+1)'(w_n);
        if (r_kind == ucrr_pkg::KIND_DATA) begin
            w_pend    = (w_nin >= (PW+1)'(MAX_PACKET)) || (w_npos >= r_len);
            w_last    = (w_npos >= r_len) || (r_cnt == 4'(ucrr_pkg::MAX_ITEMS - 1));
            w_cnt_out = w_n[3:0];
        end else begin
            w_pay     = 64'd0;
            w_pend    = 1'b1;
            w_last    = 1'b1;
            w_cnt_out = 4'd0;
        end
    end

    assign w_push     = r_busy && (!o_m_tvalid || i_m_tready);
    assign o_s_tready = !r_busy || (w_push && w_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            o_m_tvalid <= 1'b0;
            r_addr     <= 7'd0;
            r_addr_en  <= 1'b0;
            r_cfg_flag <= 1'b0;
            r_cfg_num  <= 8'd0;
            r_ep_en    <= 4'b0001;
            r_line_ok  <= 1'b0;
        end else begin
            if (w_push) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
            // A new request starts the generator even as the last reply ends.
            if (w_acc) begin
                r_busy <= 1'b1;
            end else if (w_push) begin
                r_busy <= !w_last;
            end
            if (w_acc) begin
                r_addr     <= n_addr;
                r_addr_en  <= n_addr_en;
                r_cfg_flag <= n_cfg_flag;
                r_cfg_num  <= n_cfg_num;
                r_ep_en    <= n_ep_en;
                if (w_line_we) r_line_ok <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_kind  <= n_kind;
            r_src   <= n_src;
            r_len   <= n_len;
            r_b0    <= n_b0;
            r_pos   <= 7'd0;
            r_inpkt <= '0;
            r_cnt   <= 4'd0;
        end else if (w_push) begin
            r_pos   <= w_npos;
            r_inpkt <= (w_nin >= (PW+1)'(MAX_PACKET)) ? '0 : w_nin[PW-1:0];
            r_cnt   <= r_cnt + 4'd1;
        end
        if (w_push) begin
            o_m_tdata <= {1'b0, w_pend, w_cnt_out, w_pay, r_kind};
            o_m_tlast <= w_last;
        end
    end

`include "assert_macros.svh"
    `ASSERT_IMPLY(a_count_bound, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[69:66] <= 4'(BYTES_PER_RESULT))
    `ASSERT_IMPLY(a_nodata_empty, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[1:0] != 2'(ucrr_pkg::KIND_DATA), o_m_tdata[69:66] == 4'd0 && o_m_tdata[70] && o_m_tlast)
    `ASSERT_IMPLY(a_accept_free, i_clk, i_rst_n, w_acc, !r_busy || (w_push && w_last))
    `ASSERT_NEXT(a_last_ends, i_clk, i_rst_n, w_push && w_last && !w_acc, !r_busy)
endmodule
